// ===== rtl/core/xbfr_pkg.sv =====
`timescale 1ns / 1ps

package xbfr_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int CNT_MAX     = MAX_PAYLOAD + 7;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);
  localparam int PLEN_W      = 9;
  localparam int BEAT_W      = 3;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ADDR_RX   = 8'h01;
  localparam logic [7:0] CTL_REJ0  = 8'h01;
  localparam logic [7:0] CTL_REJ1  = 8'h81;
  localparam logic [7:0] CTL_RR0   = 8'h05;
  localparam logic [7:0] CTL_RR1   = 8'h85;

  localparam logic [CNT_W-1:0] IDX_FLAG  = CNT_W'(0);
  localparam logic [CNT_W-1:0] IDX_ADDR  = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDX_CTL   = CNT_W'(2);
  localparam logic [CNT_W-1:0] IDX_HCHK  = CNT_W'(3);
  localparam logic [CNT_W-1:0] IDX_SHORT = CNT_W'(5);
  localparam logic [CNT_W-1:0] IDX_LONG  = CNT_W'(MAX_PAYLOAD + 5);
  localparam logic [CNT_W-1:0] IDX_SAT   = CNT_W'(CNT_MAX);

  localparam logic [BEAT_W-1:0] BEAT_FLAG0 = BEAT_W'(0);
  localparam logic [BEAT_W-1:0] BEAT_ADDR  = BEAT_W'(1);
  localparam logic [BEAT_W-1:0] BEAT_CTL   = BEAT_W'(2);
  localparam logic [BEAT_W-1:0] BEAT_CHK   = BEAT_W'(3);
  localparam logic [BEAT_W-1:0] BEAT_FLAG1 = BEAT_W'(4);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_FLAG  = 3'd2,
    ST_HDR   = 3'd3,
    ST_DATA  = 3'd4,
    ST_LONG  = 3'd5
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              reply;
    logic              seq;
    logic [PLEN_W-1:0] plen;
  } frame_desc_t;

endpackage

// ===== rtl/core/xbfr_in_if.sv =====
`timescale 1ns / 1ps

interface xbfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/xbfr_out_if.sv =====
`timescale 1ns / 1ps

interface xbfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_valid;
  logic       run_last;
  logic [2:0] status;
  logic [8:0] payload_length;
  logic       sequence_res;

  modport source (output valid, output reply_byte, output reply_valid, output run_last,
                  output status, output payload_length, output sequence_res,
                  input ready);
  modport sink   (input valid, input reply_byte, input reply_valid, input run_last,
                  input status, input payload_length, input sequence_res,
                  output ready);
endinterface

// ===== rtl/core/xbfr_tracker.sv =====
`timescale 1ns / 1ps

module xbfr_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  output logic                 desc_vld,
  output xbfr_pkg::frame_desc_t desc
);
  import xbfr_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             sflag_r, sflag_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       ctl_r, ctl_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             seq_r, seq_nxt;
  status_t          status;
  logic [CNT_W-1:0] plen_full;

  always_comb begin
    if (count_r < IDX_SHORT) begin
      status = ST_SHORT;
    end else if (count_r > IDX_LONG) begin
      status = ST_LONG;
    end else if (!sflag_r || rx_byte != FLAG_BYTE) begin
      status = ST_FLAG;
    end else if (!hdr_ok_r) begin
      status = ST_HDR;
    end else if (xor_r != 8'h00) begin
      status = ST_DATA;
    end else begin
      status = ST_OK;
    end
  end

  assign plen_full = count_r - IDX_SHORT;

  always_comb begin
    desc_vld    = accept && frame_end;
    desc.status = status;
    desc.reply  = (status == ST_OK) || (status == ST_DATA);
    desc.seq    = (status == ST_OK) ? ~seq_r : seq_r;
    desc.plen   = (status == ST_OK) ? plen_full[PLEN_W-1:0] : '0;
  end

  always_comb begin
    count_nxt  = count_r;
    sflag_nxt  = sflag_r;
    addr_nxt   = addr_r;
    ctl_nxt    = ctl_r;
    hdr_ok_nxt = hdr_ok_r;
    xor_nxt    = xor_r;
    seq_nxt    = seq_r;
    if (accept) begin
      if (frame_end) begin
        count_nxt  = '0;
        sflag_nxt  = 1'b0;
        hdr_ok_nxt = 1'b0;
        xor_nxt    = 8'h00;
        seq_nxt    = desc.seq;
      end else begin
        if (count_r == IDX_FLAG) begin
          sflag_nxt = (rx_byte == FLAG_BYTE);
        end else if (count_r == IDX_ADDR) begin
          addr_nxt = rx_byte;
        end else if (count_r == IDX_CTL) begin
          ctl_nxt = rx_byte;
        end else if (count_r == IDX_HCHK) begin
          hdr_ok_nxt = (rx_byte == (addr_r ^ ctl_r));
        end else begin
          xor_nxt = xor_r ^ rx_byte;
        end
        if (count_r < IDX_SAT) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sflag_r  <= 1'b0;
      hdr_ok_r <= 1'b0;
      xor_r    <= 8'h00;
      seq_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sflag_r  <= sflag_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      xor_r    <= xor_nxt;
      seq_r    <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    ctl_r  <= ctl_nxt;
  end

endmodule

// ===== rtl/core/xbfr_reply.sv =====
`timescale 1ns / 1ps

module xbfr_reply (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  desc_vld,
  input  xbfr_pkg::frame_desc_t desc,
  output logic                  slot_free,
  xbfr_out_if.source            out_ch
);
  import xbfr_pkg::*;

  logic              pend_vld_r, pend_vld_nxt;
  frame_desc_t       pend_r, pend_nxt;
  logic              act_vld_r, act_vld_nxt;
  frame_desc_t       act_r, act_nxt;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic [7:0]        ctl;
  logic [7:0]        frame_byte;
  logic              last;
  logic              act_free;

  // Control byte of the reply: RR carries the new sequence, REJ the current one.
  always_comb begin
    if (act_r.status == ST_OK) begin
      ctl = act_r.seq ? CTL_RR1 : CTL_RR0;
    end else begin
      ctl = act_r.seq ? CTL_REJ1 : CTL_REJ0;
    end
  end

  always_comb begin
    case (beat_r)
      BEAT_FLAG0: frame_byte = FLAG_BYTE;
      BEAT_ADDR:  frame_byte = ADDR_RX;
      BEAT_CTL:   frame_byte = ctl;
      BEAT_CHK:   frame_byte = ADDR_RX ^ ctl;
      BEAT_FLAG1: frame_byte = FLAG_BYTE;
      default:    frame_byte = 8'h00;
    endcase
  end

  assign last = !act_r.reply || (beat_r == BEAT_FLAG1);

  assign out_ch.valid          = act_vld_r;
  assign out_ch.reply_byte     = act_r.reply ? frame_byte : 8'h00;
  assign out_ch.reply_valid    = act_r.reply;
  assign out_ch.run_last       = last;
  assign out_ch.status         = act_r.status;
  assign out_ch.payload_length = act_r.plen;
  assign out_ch.sequence_res   = act_r.seq;

  assign act_free  = !act_vld_r || (out_ch.ready && last);
  assign slot_free = !pend_vld_r || act_free;

  always_comb begin
    act_vld_nxt  = act_vld_r;
    act_nxt      = act_r;
    beat_nxt     = beat_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (act_free) begin
      act_vld_nxt  = pend_vld_r;
      act_nxt      = pend_r;
      beat_nxt     = BEAT_FLAG0;
      pend_vld_nxt = 1'b0;
    end else if (out_ch.ready) begin
      beat_nxt = beat_r + BEAT_W'(1);
    end
    if (desc_vld) begin
      pend_vld_nxt = 1'b1;
      pend_nxt     = desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      act_vld_r  <= 1'b0;
      beat_r     <= BEAT_FLAG0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      act_vld_r  <= act_vld_nxt;
      beat_r     <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    act_r  <= act_nxt;
  end

endmodule

// ===== rtl/core/xor_bcc_frame_receiver_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Carries
// in_ch     sink       rx_byte, frame_end
// out_ch    source     reply_byte, reply_valid, run_last, status, payload_length,
//                      sequence_res
//
// One received byte is taken per cycle while in_ch is ready. A final byte leaves a
// frame verdict in a one-entry slot; the reply unit moves it to its active register
// and sends five reply bytes or one status result, one per cycle while out_ch is
// ready. Bytes of the next frame keep flowing while a reply is sent; in_ch stalls
// only while the slot still holds a verdict that the reply unit has not taken.
// Reset is synchronous and active low, and it clears the sequence bit.

module xor_bcc_frame_receiver_core (
  input  logic       clk,
  input  logic       rst_n,
  xbfr_in_if.sink    in_ch,
  xbfr_out_if.source out_ch
);
  import xbfr_pkg::*;

  logic        accept;
  logic        desc_vld;
  frame_desc_t desc;
  logic        slot_free;

  assign in_ch.ready = slot_free;
  assign accept      = in_ch.valid && slot_free;

  xbfr_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_ch.rx_byte),
    .frame_end (in_ch.frame_end),
    .desc_vld  (desc_vld),
    .desc      (desc)
  );

  xbfr_reply u_reply (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc_vld  (desc_vld),
    .desc      (desc),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import xbfr_pkg::*;

  localparam int FRAME_OVERHEAD = 6;
  localparam int RANDOM_ITEMS   = 160;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int TAIL_CYCLES    = 30;

  localparam int CORR_NONE  = 0;
  localparam int CORR_OPEN  = 1;
  localparam int CORR_CLOSE = 2;
  localparam int CORR_HDR   = 4;
  localparam int CORR_DATA  = 8;
  localparam int CORR_NOISE = 16;

  typedef struct packed {
    logic [7:0]        rbyte;
    logic              has_reply;
    logic              last;
    status_t           status;
    logic [PLEN_W-1:0] plen;
    logic              seq;
  } reply_rec_t;

  typedef struct packed {
    int      total;
    int      corrupt;
    status_t want;
  } frame_case_t;

  typedef enum int {RCV_OPEN, RCV_RANDOM, RCV_PATTERN} rcv_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  xbfr_in_if  in_ch ();
  xbfr_out_if out_ch ();

  xor_bcc_frame_receiver_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  frame_case_t directed_cases [17] = '{
    '{FRAME_OVERHEAD, CORR_NONE, ST_OK},
    '{7, CORR_NONE, ST_OK},
    '{1, CORR_NONE, ST_SHORT},
    '{5, CORR_NONE, ST_SHORT},
    '{5, CORR_OPEN | CORR_CLOSE, ST_SHORT},
    '{8, CORR_OPEN, ST_FLAG},
    '{8, CORR_CLOSE, ST_FLAG},
    '{8, CORR_HDR, ST_HDR},
    '{8, CORR_DATA, ST_DATA},
    '{9, CORR_OPEN | CORR_HDR, ST_FLAG},
    '{9, CORR_HDR | CORR_DATA, ST_HDR},
    '{FRAME_OVERHEAD, CORR_DATA, ST_DATA},
    '{MAX_PAYLOAD + FRAME_OVERHEAD, CORR_NONE, ST_OK},
    '{MAX_PAYLOAD + FRAME_OVERHEAD + 1, CORR_OPEN, ST_LONG},
    '{FRAME_OVERHEAD, CORR_NONE, ST_OK},
    '{7, CORR_NONE, ST_OK},
    '{10, CORR_DATA, ST_DATA}
  };

  reply_rec_t  pending_replies [$];
  int unsigned rx_count  = 0;
  logic        open_ok   = 1'b0;
  logic [7:0]  addr_seen = 8'h00;
  logic [7:0]  ctl_seen  = 8'h00;
  logic        hdr_ok    = 1'b0;
  logic [7:0]  bcc_acc   = 8'h00;
  logic        seq_now   = 1'b0;

  int mismatches  = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  rcv_mode_t  rcv_mode    = RCV_OPEN;
  int         rcv_left    = 0;
  int         rcv_tick    = 0;
  logic [7:0] rcv_pattern = 8'hFF;

  reply_rec_t seen_rec;
  reply_rec_t want_rec;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  function automatic void queue_reply(logic [7:0] ctl, status_t st, logic [PLEN_W-1:0] plen);
    logic [7:0] beats [5];
    beats = '{FLAG_BYTE, ADDR_RX, ctl, ADDR_RX ^ ctl, FLAG_BYTE};
    for (int k = 0; k < 5; k++) begin
      pending_replies.push_back('{beats[k], 1'b1, k == 4, st, plen, seq_now});
    end
  endfunction

  function automatic void judge_rx_byte(logic [7:0] b, logic last_byte,
                                        output status_t verdict);
    int unsigned total;
    verdict = ST_OK;
    if (!last_byte) begin
      case (rx_count)
        IDX_FLAG: open_ok = (b == FLAG_BYTE);
        IDX_ADDR: addr_seen = b;
        IDX_CTL:  ctl_seen = b;
        IDX_HCHK: hdr_ok = (b == (addr_seen ^ ctl_seen));
        default:  bcc_acc ^= b;
      endcase
      if (rx_count < CNT_MAX) rx_count++;
      return;
    end
    total = rx_count + 1;
    if (total < FRAME_OVERHEAD) verdict = ST_SHORT;
    else if (total > MAX_PAYLOAD + FRAME_OVERHEAD) verdict = ST_LONG;
    else if (!open_ok || b != FLAG_BYTE) verdict = ST_FLAG;
    else if (!hdr_ok) verdict = ST_HDR;
    else if (bcc_acc != 8'h00) verdict = ST_DATA;
    case (verdict)
      ST_OK: begin
        seq_now = ~seq_now;
        queue_reply(seq_now ? CTL_RR1 : CTL_RR0, ST_OK, PLEN_W'(total - FRAME_OVERHEAD));
      end
      ST_DATA: queue_reply(seq_now ? CTL_REJ1 : CTL_REJ0, ST_DATA, {PLEN_W{1'b0}});
      default: pending_replies.push_back('{8'h00, 1'b0, 1'b1, verdict, {PLEN_W{1'b0}},
                                           seq_now});
    endcase
    rx_count  = 0;
    open_ok   = 1'b0;
    addr_seen = 8'h00;
    ctl_seen  = 8'h00;
    hdr_ok    = 1'b0;
    bcc_acc   = 8'h00;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Short frames are cut from a well-formed minimum frame, so their closing flag
  // is cut off; send_frame still marks the last byte that remains with frame_end.
  function automatic void build_frame(int total, int corrupt, ref logic [7:0] fb [$]);
    int         n;
    logic [7:0] a;
    logic [7:0] c;
    logic [7:0] v;
    logic [7:0] acc;
    n   = (total < FRAME_OVERHEAD) ? FRAME_OVERHEAD : total;
    a   = pick_byte();
    c   = pick_byte();
    acc = 8'h00;
    fb  = '{FLAG_BYTE, a, c, a ^ c};
    for (int i = 0; i < n - FRAME_OVERHEAD; i++) begin
      v = pick_byte();
      acc ^= v;
      fb.push_back(v);
    end
    fb.push_back(acc);
    fb.push_back(FLAG_BYTE);
    if (corrupt & CORR_OPEN) fb[0] ^= 8'($urandom_range(1, 255));
    if (corrupt & CORR_CLOSE) fb[n-1] ^= 8'($urandom_range(1, 255));
    if (corrupt & CORR_HDR) fb[3] ^= 8'($urandom_range(1, 255));
    if (corrupt & CORR_DATA) fb[n-2] ^= 8'($urandom_range(1, 255));
    if (corrupt & CORR_NOISE) begin
      foreach (fb[i]) fb[i] = ($urandom_range(0, 3) == 0) ? FLAG_BYTE : pick_byte();
    end
    while (fb.size() > total) void'(fb.pop_back());
  endfunction

  task automatic send_frame(ref logic [7:0] fb [$], output status_t verdict);
    verdict = ST_OK;
    for (int i = 0; i < fb.size(); i++) begin
      if (burst_left == 0) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      in_ch.valid     = 1'b1;
      in_ch.rx_byte   = fb[i];
      in_ch.frame_end = (i == fb.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      judge_rx_byte(fb[i], i == fb.size() - 1, verdict);
      @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode    = rcv_mode_t'($urandom_range(0, 2));
      rcv_left    = $urandom_range(20, 80);
      rcv_pattern = 8'($urandom_range(1, 255));
    end
    rcv_left--;
    rcv_tick++;
    case (rcv_mode)
      RCV_OPEN:   out_ch.ready = 1'b1;
      RCV_RANDOM: out_ch.ready = ($urandom_range(0, 3) != 0);
      default:    out_ch.ready = rcv_pattern[rcv_tick[2:0]];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_rec = '{out_ch.reply_byte, out_ch.reply_valid, out_ch.run_last,
                   status_t'(out_ch.status), out_ch.payload_length, out_ch.sequence_res};
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", seen_rec));
      end else begin
        want_rec = pending_replies.pop_front();
        if (seen_rec !== want_rec) begin
          report_mismatch($sformatf("got %p, expected %p", seen_rec, want_rec));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [7:0] frame_bytes [$];
    status_t    verdict;
    int         total;
    int         corrupt;
    int         sent;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = 8'h00;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_cases[k]) begin
      build_frame(directed_cases[k].total, directed_cases[k].corrupt, frame_bytes);
      send_frame(frame_bytes, verdict);
      if (verdict != directed_cases[k].want) begin
        report_mismatch($sformatf("directed frame %0d judged %s, table gives %s", k,
                                  verdict.name(), directed_cases[k].want.name()));
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          total   = $urandom_range(1, 12);
          corrupt = CORR_NOISE;
        end
        1, 2: begin
          total   = $urandom_range(FRAME_OVERHEAD, 14);
          corrupt = CORR_OPEN << $urandom_range(0, 3);
        end
        default: begin
          total   = FRAME_OVERHEAD + (($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                                  : $urandom_range(0, 8));
          corrupt = CORR_NONE;
        end
      endcase
      build_frame(total, corrupt, frame_bytes);
      send_frame(frame_bytes, verdict);
      sent += total;
    end
    in_ch.valid = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
